[design/pafm_pkg.sv]
package pafm_pkg;

    localparam int COORD_BITS = 9;
    localparam int COUNT_BITS = 18;
    localparam int FRAC_BITS  = 16;

    localparam int N_W   = COUNT_BITS + 1;
    localparam int SUM_W = COORD_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * COORD_BITS + COUNT_BITS;

    localparam int A_W   = 35;
    localparam int B_W   = 35;
    localparam int C_W   = 45;
    localparam int EIG_W = 36;

    localparam int IN_RAW_W   = N_W + 2 * SUM_W + 3 * SQ_W;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = A_W + B_W + C_W + 2 * EIG_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int PROD_W  = N_W + SQ_W;
    localparam int DEN_W   = 2 * N_W;
    localparam int VNUM_W  = PROD_W + FRAC_BITS + 1;
    localparam int MNUM_W  = SUM_W + FRAC_BITS + 1;
    localparam int VAR_QB  = 2 * COORD_BITS + FRAC_BITS;
    localparam int MEAN_QB = COORD_BITS + FRAC_BITS;
    localparam int VAR_W   = VAR_QB + 1;
    localparam int DD_W    = VAR_QB + 2;
    localparam int AD_W    = VAR_QB + 1;
    localparam int SQIN_W  = 2 * AD_W + 2;
    localparam int SQ_RB   = SQIN_W / 2;
    localparam int D_W     = SQ_RB + 1;
    localparam int T_W     = D_W + 2;
    localparam int AI_W    = D_W;
    localparam int P_W     = MEAN_QB + AI_W;
    localparam int TOT_W   = P_W + 1;

    localparam int DIV_LAT    = VAR_QB + 1;
    localparam int SQRT_LAT   = SQ_RB + 1;
    localparam int PIPE_DEPTH = 9 + DIV_LAT + SQRT_LAT;

    localparam logic [MEAN_QB-1:0] MEAN_MAX = '1;
    localparam logic [A_W-1:0]     A_MAX    = '1;
    localparam logic [EIG_W-1:0]   EIG_MAX  = '1;
    localparam logic [A_W-1:0]     A_ONE    = A_W'(1) << FRAC_BITS;
    localparam logic [B_W-1:0]     B_ONE    = B_W'(1) << FRAC_BITS;
    localparam logic [TOT_W-1:0]   C_LIM_NEG = TOT_W'((64'd1 << (C_W - 1)) - 64'd1);
    localparam logic [TOT_W-1:0]   C_LIM_POS = TOT_W'(64'd1 << (C_W - 1));
    localparam logic [TOT_W-1:0]   C_HALF    = TOT_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic       few;
        logic       zxy;
        logic [2:0] neg;
    } front_t;

    typedef struct packed {
        logic               few;
        logic               zxy;
        logic [VAR_W-1:0]   vxx;
        logic [VAR_W-1:0]   vyy;
        logic [VAR_W-1:0]   vxy;
        logic [DD_W-1:0]    dd;
        logic [MEAN_QB-1:0] mx;
        logic [MEAN_QB-1:0] my;
    } back_t;

endpackage

[design/pafm_div.sv]
module pafm_div #(
    parameter int NUM_W = 72,
    parameter int DEN_W = 38,
    parameter int QB    = 34
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QB-1:0]    quo
);

    localparam int X_W = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

    logic [X_W-1:0]   rem_reg [QB+1];
    logic [DEN_W-1:0] den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             sat_reg [QB+1];

    // quotient at or above 2^QB saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= X_W'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= X_W'(num) >= X_W'({den, {QB{1'b0}}});
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [X_W-1:0] trial;
        logic           ge;
        logic [X_W-1:0] rem_next;
        logic [QB-1:0]  q_next;

        always_comb
        begin
            trial    = X_W'(den_reg[k]) << (QB - 1 - k);
            ge       = rem_reg[k] >= trial;
            rem_next = ge ? rem_reg[k] - trial : rem_reg[k];
            q_next   = ge ? (q_reg[k] | (QB'(1) << (QB - 1 - k))) : q_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_next;
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign quo = sat_reg[QB] ? '1 : q_reg[QB];

endmodule

[design/pafm_sqrt.sv]
module pafm_sqrt #(
    parameter int IN_W = 72,
    parameter int RB   = 36
) (
    input  logic          clk,
    input  logic          en,
    input  logic [IN_W-1:0] val,
    output logic [RB:0]   root
);

    logic [IN_W-1:0] num_reg [RB];
    logic [IN_W-1:0] res_reg [RB];
    logic [RB:0]     root_reg;

    for (genvar k = 0; k < RB; k++)
    begin : g_step
        logic [IN_W-1:0] num_in;
        logic [IN_W-1:0] res_in;
        logic [IN_W-1:0] bit_k;
        logic [IN_W-1:0] trial;
        logic            ge;
        logic [IN_W-1:0] num_next;
        logic [IN_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign num_in = val;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign num_in = num_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            bit_k    = IN_W'(1) << (2 * (RB - 1 - k));
            trial    = res_in + bit_k;
            ge       = num_in >= trial;
            num_next = ge ? num_in - trial : num_in;
            res_next = ge ? (res_in >> 1) + bit_k : res_in >> 1;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_next;
                res_reg[k] <= res_next;
            end
        end
    end

    // round to nearest: bump when remainder exceeds the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= (RB + 1)'(res_reg[RB-1][RB-1:0])
                      + (RB + 1)'(num_reg[RB-1] > res_reg[RB-1]);
        end
    end

    assign root = root_reg;

endmodule

[design/principal_axis_from_moments.sv]
// Principal-axis line from 2D point-set moments. Each transfer on s_axis carries
// the point count and the sums of x, y, x*x, y*y and x*y; one transfer leaves on
// m_axis with the line a*x + b*y + c = 0 along the second principal axis and both
// covariance eigenvalues, all with 16 fractional bits. A new transfer is taken in
// every cycle unless the output stalls; the pipeline is 81 stages deep. The depth is
// set by the bit-per-stage dividers for the variances and means (35 stages) and
// the bit-per-stage square root (37 stages). tuser flags a set of fewer than two
// points, in which case tdata is zero. When a result waits at the output and
// m_axis_tready is low, the whole pipeline holds and s_axis_tready is low.
module principal_axis_from_moments (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_count, sum_row, sum_col, sum_row_sq, sum_col_sq, sum_cross
    input  logic [pafm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // coef_a, coef_b, coef_c, eigen_major, eigen_minor
    output logic [pafm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // too_few_points
    output logic                                m_axis_tuser
);

    import pafm_pkg::*;

    logic pipe_en;
    logic valid_reg [PIPE_DEPTH];

    // stage 1
    logic [N_W-1:0]   n1_reg;
    logic [SUM_W-1:0] sx1_reg, sy1_reg;
    logic [SQ_W-1:0]  s2_1_reg [3];

    // stage 2
    logic [PROD_W-1:0] p2_reg [3];
    logic [PROD_W-1:0] q2_reg [3];
    logic [DEN_W-1:0]  den2_reg;
    logic [MNUM_W-1:0] mnum2_reg [2];
    logic [N_W-1:0]    n2_reg;
    logic              few2_reg;

    // stage 3
    logic [VNUM_W-1:0] vnum3_reg [3];
    logic [VNUM_W-1:0] vnum3_next [3];
    logic [2:0]        neg3_next;
    logic [2:0]        z3_next;
    logic [DEN_W-1:0]  den3_reg;
    logic [MNUM_W-1:0] mnum3_reg [2];
    logic [N_W-1:0]    n3_reg;
    front_t            front3_reg;
    front_t            front_pipe_reg [DIV_LAT];

    logic [VAR_QB-1:0] vq [3];
    logic [VAR_QB-1:0] mq [2];

    // stages 4 to 6
    back_t             back4_next, back4_reg, back5_reg, back6_reg;
    logic [AD_W-1:0]   ad4_reg;
    logic [VAR_QB-1:0] av4_reg;
    logic [SQIN_W-1:0] ad2_5_reg, av2_5_reg, sq6_reg;
    back_t             back_pipe_reg [SQRT_LAT];
    logic [D_W-1:0]    d_root;

    // stages 7 to 9
    back_t             bd;
    logic signed [T_W-1:0] dd_t, d_t, vxx_t, vyy_t, a_sum, tmaj, tmin;
    logic [AI_W-1:0]   a7_reg;
    logic [EIG_W-1:0]  emaj7_reg, emin7_reg, emaj8_reg, emin8_reg;
    logic [VAR_W-1:0]  vxy7_reg, vxy8_reg;
    logic [VAR_QB-1:0] avxy7_reg;
    logic [MEAN_QB-1:0] mx7_reg, my7_reg, mx8_reg, my8_reg;
    logic              zxy7_reg, vge7_reg, few7_reg, zxy8_reg, vge8_reg, few8_reg;
    logic [AI_W-1:0]   a8_reg;
    logic [P_W-1:0]    p1_8_reg, p2_8_reg;

    logic [TOT_W-1:0]  tot9, cm9, mag9;
    logic              tneg9;
    logic [C_W-1:0]    c_gen9;
    logic [A_W-1:0]    a_out_next, a_out_reg;
    logic [B_W-1:0]    b_out_next, b_out_reg;
    logic [C_W-1:0]    c_out_next, c_out_reg;
    logic [EIG_W-1:0]  emaj_out_reg, emin_out_reg;
    logic              few_out_reg;

    function automatic logic [EIG_W-1:0] half_eigen(input logic signed [T_W-1:0] t);
        logic [T_W-1:0] h;
        h = T_W'(t + T_W'(1)) >> 1;
        if (t <= 0)
            return '0;
        else if (h > T_W'(EIG_MAX))
            return EIG_MAX;
        else
            return h[EIG_W-1:0];
    endfunction

    assign pipe_en       = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (pipe_en)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: capture
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            n1_reg      <= s_axis_tdata[N_W-1:0];
            sx1_reg     <= s_axis_tdata[N_W +: SUM_W];
            sy1_reg     <= s_axis_tdata[N_W + SUM_W +: SUM_W];
            s2_1_reg[0] <= s_axis_tdata[N_W + 2 * SUM_W +: SQ_W];
            s2_1_reg[1] <= s_axis_tdata[N_W + 2 * SUM_W + SQ_W +: SQ_W];
            s2_1_reg[2] <= s_axis_tdata[N_W + 2 * SUM_W + 2 * SQ_W +: SQ_W];
        end
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
                p2_reg[i] <= PROD_W'(n1_reg) * PROD_W'(s2_1_reg[i]);
            q2_reg[0]    <= PROD_W'(sx1_reg) * PROD_W'(sx1_reg);
            q2_reg[1]    <= PROD_W'(sy1_reg) * PROD_W'(sy1_reg);
            q2_reg[2]    <= PROD_W'(sx1_reg) * PROD_W'(sy1_reg);
            den2_reg     <= DEN_W'(n1_reg) * DEN_W'(N_W'(n1_reg - N_W'(1)));
            mnum2_reg[0] <= MNUM_W'({sx1_reg, {FRAC_BITS{1'b0}}}) + MNUM_W'(n1_reg >> 1);
            mnum2_reg[1] <= MNUM_W'({sy1_reg, {FRAC_BITS{1'b0}}}) + MNUM_W'(n1_reg >> 1);
            n2_reg       <= n1_reg;
            few2_reg     <= n1_reg < N_W'(2);
        end
    end

    // stage 3: variance numerators
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [PROD_W-1:0] m;
            neg3_next[i]  = p2_reg[i] < q2_reg[i];
            m             = neg3_next[i] ? q2_reg[i] - p2_reg[i] : p2_reg[i] - q2_reg[i];
            z3_next[i]    = m == '0;
            vnum3_next[i] = (VNUM_W'(m) << FRAC_BITS) + VNUM_W'(den2_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
                vnum3_reg[i] <= vnum3_next[i];
            den3_reg       <= den2_reg;
            mnum3_reg[0]   <= mnum2_reg[0];
            mnum3_reg[1]   <= mnum2_reg[1];
            n3_reg         <= n2_reg;
            front3_reg.few <= few2_reg;
            front3_reg.zxy <= z3_next[2];
            front3_reg.neg <= neg3_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_vdiv
        pafm_div #(
            .NUM_W (VNUM_W),
            .DEN_W (DEN_W),
            .QB    (VAR_QB)
        ) u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (vnum3_reg[i]),
            .den (den3_reg),
            .quo (vq[i])
        );
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_mdiv
        pafm_div #(
            .NUM_W (MNUM_W),
            .DEN_W (N_W),
            .QB    (VAR_QB)
        ) u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (mnum3_reg[j]),
            .den (n3_reg),
            .quo (mq[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            front_pipe_reg[0] <= front3_reg;
            for (int i = 1; i < DIV_LAT; i++)
                front_pipe_reg[i] <= front_pipe_reg[i-1];
        end
    end

    // stage 4: signed variances, means, difference
    always_comb
    begin
        logic [VAR_W-1:0] v [3];
        for (int i = 0; i < 3; i++)
            v[i] = front_pipe_reg[DIV_LAT-1].neg[i] ? VAR_W'(0) - VAR_W'(vq[i])
                                                    : VAR_W'(vq[i]);
        back4_next.few = front_pipe_reg[DIV_LAT-1].few;
        back4_next.zxy = front_pipe_reg[DIV_LAT-1].zxy;
        back4_next.vxx = v[0];
        back4_next.vyy = v[1];
        back4_next.vxy = v[2];
        back4_next.dd  = DD_W'($signed(v[0])) - DD_W'($signed(v[1]));
        back4_next.mx  = (mq[0] > VAR_QB'(MEAN_MAX)) ? MEAN_MAX : mq[0][MEAN_QB-1:0];
        back4_next.my  = (mq[1] > VAR_QB'(MEAN_MAX)) ? MEAN_MAX : mq[1][MEAN_QB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            back4_reg <= back4_next;
            ad4_reg   <= back4_next.dd[DD_W-1] ? AD_W'(DD_W'(0) - back4_next.dd)
                                               : AD_W'(back4_next.dd);
            av4_reg   <= vq[2];
            back5_reg <= back4_reg;
            ad2_5_reg <= SQIN_W'(ad4_reg) * SQIN_W'(ad4_reg);
            av2_5_reg <= SQIN_W'(av4_reg) * SQIN_W'(av4_reg);
            back6_reg <= back5_reg;
            sq6_reg   <= ad2_5_reg + (av2_5_reg << 2);
        end
    end

    pafm_sqrt #(
        .IN_W (SQIN_W),
        .RB   (SQ_RB)
    ) u_sqrt (
        .clk  (clk),
        .en   (pipe_en),
        .val  (sq6_reg),
        .root (d_root)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            back_pipe_reg[0] <= back6_reg;
            for (int i = 1; i < SQRT_LAT; i++)
                back_pipe_reg[i] <= back_pipe_reg[i-1];
        end
    end

    // stage 7: line coefficient a and eigenvalues
    always_comb
    begin
        bd    = back_pipe_reg[SQRT_LAT-1];
        dd_t  = T_W'($signed(bd.dd));
        vxx_t = T_W'($signed(bd.vxx));
        vyy_t = T_W'($signed(bd.vyy));
        d_t   = $signed(T_W'(d_root));
        a_sum = dd_t + d_t + T_W'(1);
        tmaj  = vxx_t + vyy_t + d_t;
        tmin  = vxx_t + vyy_t - d_t;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a7_reg    <= a_sum[AI_W:1];
            emaj7_reg <= half_eigen(tmaj);
            emin7_reg <= half_eigen(tmin);
            vxy7_reg  <= bd.vxy;
            avxy7_reg <= bd.vxy[VAR_W-1] ? VAR_QB'(VAR_W'(0) - bd.vxy) : bd.vxy[VAR_QB-1:0];
            mx7_reg   <= bd.mx;
            my7_reg   <= bd.my;
            zxy7_reg  <= bd.zxy;
            vge7_reg  <= $signed(bd.vxx) >= $signed(bd.vyy);
            few7_reg  <= bd.few;
        end
    end

    // stage 8: products for the constant term
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            p1_8_reg  <= P_W'(mx7_reg) * P_W'(a7_reg);
            p2_8_reg  <= P_W'(my7_reg) * P_W'(avxy7_reg);
            a8_reg    <= a7_reg;
            emaj8_reg <= emaj7_reg;
            emin8_reg <= emin7_reg;
            vxy8_reg  <= vxy7_reg;
            mx8_reg   <= mx7_reg;
            my8_reg   <= my7_reg;
            zxy8_reg  <= zxy7_reg;
            vge8_reg  <= vge7_reg;
            few8_reg  <= few7_reg;
        end
    end

    // stage 9: constant term, special cases, output register
    always_comb
    begin
        if (!vxy8_reg[VAR_W-1])
        begin
            tot9  = TOT_W'(p1_8_reg) + TOT_W'(p2_8_reg);
            tneg9 = 1'b0;
        end
        else if (p1_8_reg >= p2_8_reg)
        begin
            tot9  = TOT_W'(p1_8_reg - p2_8_reg);
            tneg9 = 1'b0;
        end
        else
        begin
            tot9  = TOT_W'(p2_8_reg - p1_8_reg);
            tneg9 = 1'b1;
        end
        cm9 = (tot9 + C_HALF) >> FRAC_BITS;
        if (tneg9)
            mag9 = (cm9 > C_LIM_NEG) ? C_LIM_NEG : cm9;
        else
            mag9 = (cm9 > C_LIM_POS) ? C_LIM_POS : cm9;
        c_gen9 = tneg9 ? C_W'(mag9) : C_W'(0) - C_W'(mag9);

        if (few8_reg)
        begin
            a_out_next = '0;
            b_out_next = '0;
            c_out_next = '0;
        end
        else if (!zxy8_reg)
        begin
            a_out_next = (a8_reg > AI_W'(A_MAX)) ? A_MAX : a8_reg[A_W-1:0];
            b_out_next = B_W'($signed(vxy8_reg));
            c_out_next = c_gen9;
        end
        else if (vge8_reg)
        begin
            a_out_next = A_ONE;
            b_out_next = '0;
            c_out_next = C_W'(0) - C_W'(mx8_reg);
        end
        else
        begin
            a_out_next = '0;
            b_out_next = B_ONE;
            c_out_next = C_W'(0) - C_W'(my8_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_out_reg    <= a_out_next;
            b_out_reg    <= b_out_next;
            c_out_reg    <= c_out_next;
            emaj_out_reg <= few8_reg ? '0 : emaj8_reg;
            emin_out_reg <= few8_reg ? '0 : emin8_reg;
            few_out_reg  <= few8_reg;
        end
    end

    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tuser  = few_out_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}},
                            emin_out_reg, emaj_out_reg, c_out_reg, b_out_reg, a_out_reg};

    a_few_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("too few points but nonzero result");

    a_eig_order : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> emaj_out_reg >= emin_out_reg)
        else $error("eigenvalues out of order");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(a_out_reg) && $stable(c_out_reg) && $stable(valid_reg[0]))
        else $error("pipeline moved during stall");

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pafm_pkg::*;

    localparam logic [127:0] VAR_LIM   = (128'd1 << VAR_QB) - 1;
    localparam logic [127:0] MEAN_LIM  = (128'd1 << MEAN_QB) - 1;
    localparam longint       A_LIM     = (64'sd1 << A_W) - 1;
    localparam longint       B_HI      = (64'sd1 << (B_W - 1)) - 1;
    localparam longint       C_HI      = (64'sd1 << (C_W - 1)) - 1;
    localparam longint       EIG_LIM   = (64'sd1 << EIG_W) - 1;
    localparam longint       ONE_Q16   = 64'sd1 << FRAC_BITS;
    localparam int           N_ITEMS   = 1450;
    localparam int           DRAIN_AT  = 700;
    localparam int           CALM_TAIL = 200;

    typedef struct packed {
        logic [SQ_W-1:0]  sum_cross;
        logic [SQ_W-1:0]  sum_col_sq;
        logic [SQ_W-1:0]  sum_row_sq;
        logic [SUM_W-1:0] sum_col;
        logic [SUM_W-1:0] sum_row;
        logic [N_W-1:0]   point_count;
    } moments_t;

    typedef struct packed {
        logic               too_few;
        logic [EIG_W-1:0]   eigen_minor;
        logic [EIG_W-1:0]   eigen_major;
        logic signed [C_W-1:0] coef_c;
        logic signed [B_W-1:0] coef_b;
        logic [A_W-1:0]     coef_a;
    } axis_line_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    moments_t   pending_sets[$];
    axis_line_t expected_lines[$];
    int         sent_count;
    int         error_count;
    int         send_gap;
    int         recv_stall;
    bit         drained;
    bit         in_held;

    principal_axis_from_moments dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sample_var(logic [127:0] n, logic [127:0] s2,
                                          logic [127:0] sa, logic [127:0] sb,
                                          logic [127:0] den, output bit is_zero);
        logic [127:0] p;
        logic [127:0] q;
        logic [127:0] m;
        bit           neg;
        longint       v;
        p = n * s2;
        q = sa * sb;
        neg = p < q;
        m = neg ? q - p : p - q;
        is_zero = (m == 0);
        m = ((m << FRAC_BITS) + (den >> 1)) / den;
        if (m > VAR_LIM)
            m = VAR_LIM;
        v = longint'(m[63:0]);
        return neg ? -v : v;
    endfunction

    function automatic longint mean_q(logic [127:0] s, logic [127:0] n);
        logic [127:0] m;
        m = ((s << FRAC_BITS) + (n >> 1)) / n;
        if (m > MEAN_LIM)
            m = MEAN_LIM;
        return longint'(m[63:0]);
    endfunction

    function automatic longint half_eigen(longint t);
        longint h;
        if (t <= 0)
            return 0;
        h = (t + 1) / 2;
        return h > EIG_LIM ? EIG_LIM : h;
    endfunction

    function automatic axis_line_t principal_axis_of(moments_t mo);
        axis_line_t   r;
        logic [127:0] n;
        logic [127:0] den;
        logic [127:0] ad;
        logic [127:0] avxy;
        logic [127:0] arg;
        logic [127:0] s;
        logic [127:0] t;
        logic [127:0] p1;
        logic [127:0] p2;
        logic [127:0] tot;
        logic [127:0] lim;
        bit           zxx;
        bit           zyy;
        bit           zxy;
        bit           tneg;
        longint       vxx;
        longint       vyy;
        longint       vxy;
        longint       mx;
        longint       my;
        longint       dd;
        longint       d;
        longint       a;
        longint       b;
        longint       c;
        r = '0;
        n = mo.point_count;
        if (n < 2)
        begin
            r.too_few = 1'b1;
            return r;
        end
        den = n * (n - 1);
        vxx = sample_var(n, mo.sum_row_sq, mo.sum_row, mo.sum_row, den, zxx);
        vyy = sample_var(n, mo.sum_col_sq, mo.sum_col, mo.sum_col, den, zyy);
        vxy = sample_var(n, mo.sum_cross, mo.sum_row, mo.sum_col, den, zxy);
        mx = mean_q(mo.sum_row, n);
        my = mean_q(mo.sum_col, n);
        dd = vxx - vyy;
        ad = dd < 0 ? -dd : dd;
        avxy = vxy < 0 ? -vxy : vxy;
        arg = ad * ad + ((avxy * avxy) << 2);
        // rounded square root
        s = 0;
        for (int k = 63; k >= 0; k--)
        begin
            t = s | (128'd1 << k);
            if (t * t <= arg)
                s = t;
        end
        if (arg - s * s > s)
            s = s + 1;
        d = longint'(s[63:0]);
        if (!zxy)
        begin
            a = (dd + d + 1) / 2;
            b = vxy;
            p1 = mx * a;
            p2 = my * avxy;
            tneg = 1'b0;
            if (vxy >= 0)
                tot = p1 + p2;
            else if (p1 >= p2)
                tot = p1 - p2;
            else
            begin
                tot = p2 - p1;
                tneg = 1'b1;
            end
            tot = (tot + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            lim = tneg ? (128'd1 << (C_W - 1)) - 1 : (128'd1 << (C_W - 1));
            if (tot > lim)
                tot = lim;
            c = tneg ? longint'(tot[63:0]) : -longint'(tot[63:0]);
        end
        else if (vxx >= vyy)
        begin
            a = ONE_Q16;
            b = 0;
            c = -mx;
        end
        else
        begin
            a = 0;
            b = ONE_Q16;
            c = -my;
        end
        if (a > A_LIM)
            a = A_LIM;
        if (b > B_HI)
            b = B_HI;
        if (b < -B_HI - 1)
            b = -B_HI - 1;
        if (c > C_HI)
            c = C_HI;
        if (c < -C_HI - 1)
            c = -C_HI - 1;
        r.coef_a = a[A_W-1:0];
        r.coef_b = b[B_W-1:0];
        r.coef_c = c[C_W-1:0];
        r.eigen_major = half_eigen(vxx + vyy + d);
        r.eigen_minor = half_eigen(vxx + vyy - d);
        return r;
    endfunction

    task automatic add_moments(longint unsigned n, longint unsigned sx, longint unsigned sy,
                               longint unsigned sxx, longint unsigned syy,
                               longint unsigned sxy);
        moments_t mo;
        mo.point_count = N_W'(n);
        mo.sum_row     = SUM_W'(sx);
        mo.sum_col     = SUM_W'(sy);
        mo.sum_row_sq  = SQ_W'(sxx);
        mo.sum_col_sq  = SQ_W'(syy);
        mo.sum_cross   = SQ_W'(sxy);
        pending_sets.push_back(mo);
    endtask

    // consistent sums from a few weighted points; shape 0 random, 1 horizontal,
    // 2 vertical, 3 diagonal, 4 one repeated point
    task automatic add_point_set(int shape, bit heavy);
        longint unsigned n;
        longint unsigned sx;
        longint unsigned sy;
        longint unsigned sxx;
        longint unsigned syy;
        longint unsigned sxy;
        longint unsigned x;
        longint unsigned y;
        longint unsigned w;
        int              kpts;
        int              base;
        kpts = (shape == 4) ? 1 : $urandom_range(2, 6);
        base = $urandom_range(0, 511);
        {n, sx, sy, sxx, syy, sxy} = '0;
        for (int i = 0; i < kpts; i++)
        begin
            x = $urandom_range(0, 511);
            y = $urandom_range(0, 511);
            if (shape == 1)
                y = base;
            if (shape == 2)
                x = base;
            if (shape == 3)
                y = x;
            if (shape == 4)
                x = base;
            w = heavy ? $urandom_range(1, 262144 / kpts) : $urandom_range(1, 40);
            if (shape == 4)
                w = $urandom_range(2, heavy ? 262144 : 40);
            n += w;
            sx += w * x;
            sy += w * y;
            sxx += w * x * x;
            syy += w * y * y;
            sxy += w * x * y;
        end
        add_moments(n, sx, sy, sxx, syy, sxy);
    endtask

    function automatic longint unsigned rand_bits();
        return {$urandom(), $urandom()};
    endfunction

    // input driver; an offered transfer is held until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (sent_count == DRAIN_AT && !drained)
        begin
            if (expected_lines.size() == 0)
                drained = 1'b1;
            s_axis_tvalid <= 1'b0;
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end
        else if (!in_held && pending_sets.size() > CALM_TAIL && $urandom_range(0, 15) == 0)
        begin
            send_gap = $urandom_range(1, 14) - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_sets.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= IN_DATA_W'(pending_sets[0]);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // output ready with stall bursts
    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (pending_sets.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
        begin
            recv_stall = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // accepted input transfer -> expected line
    always @(posedge clk)
    begin
        if (rst_n)
            in_held = s_axis_tvalid && !s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_lines.push_back(principal_axis_of(moments_t'(s_axis_tdata[IN_RAW_W-1:0])));
            void'(pending_sets.pop_front());
            sent_count++;
        end
    end

    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // output monitor
    always @(posedge clk)
    begin
        axis_line_t want;
        axis_line_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[OUT_RAW_W-1:0]};
            if (expected_lines.size() == 0)
            begin
                $display("%0t: unexpected output transfer, expected none, actual %0h",
                         $realtime, got);
                error_count++;
            end
            else
            begin
                want = expected_lines.pop_front();
                report_field("coef_a", want.coef_a, got.coef_a);
                report_field("coef_b", want.coef_b, got.coef_b);
                report_field("coef_c", want.coef_c, got.coef_c);
                report_field("eigen_major", want.eigen_major, got.eigen_major);
                report_field("eigen_minor", want.eigen_minor, got.eigen_minor);
                report_field("too_few_points", want.too_few, got.too_few);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sent_count = 0;
        error_count = 0;
        send_gap = 0;
        recv_stall = 0;
        drained = 1'b0;
        in_held = 1'b0;

        // too few points, minimum and maximum count, extremes of the sums
        add_moments(0, 0, 0, 0, 0, 0);
        add_moments(1, 300, 200, 90000, 40000, 60000);
        add_moments(2, 0, 0, 0, 0, 0);
        add_moments(2, 511, 511, 261121, 261121, 0);
        add_moments(2, 511, 0, 261121, 0, 0);
        add_moments(262144, 133955584, 133955584, 68451041280, 68451041280, 68451041280);
        add_moments(262144, 0, 0, 0, 0, 0);
        add_moments((1 << N_W) - 1, (1 << SUM_W) - 1, (1 << SUM_W) - 1,
                    (64'd1 << SQ_W) - 1, (64'd1 << SQ_W) - 1, (64'd1 << SQ_W) - 1);
        add_moments(2, (1 << SUM_W) - 1, 0, 0, (64'd1 << SQ_W) - 1, 0);
        add_moments(3, 0, 0, (64'd1 << SQ_W) - 1, 0, (64'd1 << SQ_W) - 1);
        // zero covariance with either variance larger, covariance rounding to zero
        add_moments(3, 3, 6, 5, 12, 6);
        add_moments(3, 6, 3, 12, 5, 6);
        add_moments(262144, 1, 1, 1, 1, 1);
        add_moments(3, 3, 3, 5, 5, 5);
        for (int shape = 0; shape < 5; shape++)
        begin
            add_point_set(shape, 1'b0);
            add_point_set(shape, 1'b1);
        end

        while (pending_sets.size() < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    add_moments(rand_bits(), rand_bits(), rand_bits(), rand_bits(),
                                rand_bits(), rand_bits());
                2:
                    add_moments($urandom_range(0, 3), rand_bits(), rand_bits(), rand_bits(),
                                rand_bits(), rand_bits());
                default:
                    add_point_set($urandom_range(0, 4), $urandom_range(0, 4) == 0);
            endcase
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_sets.size() == 0 && expected_lines.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/pafm_pkg.sv
design/pafm_div.sv
design/pafm_sqrt.sv
design/principal_axis_from_moments.sv
test/tb_top.sv
